/* sv/pfc_pkg.sv */
// pfc_pkg: shared types, constants and the lfsr step for the prbs frame checker
// no dependencies; compiled first

package pfc_pkg;

	localparam int DEF_MIN_WORDS = 3;
	localparam int DEF_MAX_WORDS = 65536;

	localparam int WORD_W = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_LEN   = 2'd2,
		ST_DATA  = 2'd3
	} status_t;

	// left shift, feedback from bits 1, 2, 6 and 31 enters at bit 0
	function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] s);
		logic fb;
		fb = s[1] ^ s[2] ^ s[6] ^ s[31];
		return {s[WORD_W-2:0], fb};
	endfunction

endpackage

/* sv/pfc_if.sv */
// pfc_in_if / pfc_out_if: valid-ready channels for frame words and frame results
// depends on pfc_pkg

interface pfc_in_if;
	import pfc_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (output valid, output word, output last, input ready);
	modport sink   (input valid, input word, input last, output ready);
endinterface

interface pfc_out_if;
	import pfc_pkg::*;
	logic              valid;
	logic              ready;
	status_t           status;
	logic [WORD_W-1:0] frame_seq;

	modport source (output valid, output status, output frame_seq, input ready);
	modport sink   (input valid, input status, input frame_seq, output ready);
endinterface

/* sv/prbs_frame_checker.sv */
// prbs_frame_checker: checks each frame against a 32-bit lfsr, one status per frame
// depends on pfc_pkg and the channel interfaces in pfc_if.sv
//
//  channel  dir  payload                 transfer
//  frame    in   word[31:0], last        frame.valid & frame.ready
//  result   out  status[1:0], frame_seq  result.valid & result.ready
//
// one word per cycle while frame.ready is high; the frame state updates at the word transfer
// the status of a frame is in the result register in the cycle after its last word
// the result register takes a new status in the cycle its old one is transferred
// frame.ready drops only while a result waits and result.ready is low
// arst_n clears the frame state and the result valid flag

module prbs_frame_checker #(
	parameter int MIN_WORDS = pfc_pkg::DEF_MIN_WORDS,
	parameter int MAX_WORDS = pfc_pkg::DEF_MAX_WORDS
) (
	input logic      clk,
	input logic      arst_n,
	pfc_in_if.sink   frame,
	pfc_out_if.source result
);
	import pfc_pkg::*;

	localparam int CNT_W = $clog2(MAX_WORDS + 1);

	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] lfsr_q;
	logic [WORD_W-1:0] seq_q;
	logic [WORD_W-1:0] len_q;
	logic              mismatch_q;
	logic              overflow_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [WORD_W-1:0] frame_seq_q;

	logic              xfer;
	logic              at_max;
	logic [CNT_W-1:0]  count_new;
	logic [WORD_W-1:0] lfsr_step;
	logic [WORD_W-1:0] lfsr_new;
	logic [WORD_W-1:0] seq_new;
	logic [WORD_W-1:0] len_new;
	logic [WORD_W-1:0] len_plus;
	logic              mismatch_new;
	logic              overflow_new;
	status_t           status_new;

	assign frame.ready = !out_valid_q || result.ready;
	assign xfer = frame.valid && frame.ready;

	always_comb begin
		at_max = (count_q == CNT_W'(MAX_WORDS));
		count_new = at_max ? count_q : count_q + CNT_W'(1);
		overflow_new = overflow_q || at_max;
		lfsr_step = lfsr_next(lfsr_q);
		lfsr_new = lfsr_step;
		seq_new = seq_q;
		len_new = len_q;
		mismatch_new = mismatch_q;
		if (count_q == '0) begin
			seq_new = frame.word;
			lfsr_new = frame.word;
		end else if (count_q == CNT_W'(1)) begin
			len_new = frame.word;
			lfsr_new = lfsr_q;
		end else begin
			mismatch_new = mismatch_q || (frame.word != lfsr_step);
		end
		// byte counts agree mod 2^32 when len+1 and the word count agree mod 2^30
		len_plus = len_new + WORD_W'(1);
		if (32'(count_new) < 32'(MIN_WORDS)) begin
			status_new = ST_SHORT;
		end else if (overflow_new || (len_plus[29:0] != 30'(count_new))) begin
			status_new = ST_LEN;
		end else if (mismatch_new) begin
			status_new = ST_DATA;
		end else begin
			status_new = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			lfsr_q     <= '0;
			seq_q      <= '0;
			len_q      <= '0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (xfer) begin
			if (frame.last) begin
				count_q    <= '0;
				lfsr_q     <= '0;
				seq_q      <= '0;
				len_q      <= '0;
				mismatch_q <= 1'b0;
				overflow_q <= 1'b0;
			end else begin
				count_q    <= count_new;
				lfsr_q     <= lfsr_new;
				seq_q      <= seq_new;
				len_q      <= len_new;
				mismatch_q <= mismatch_new;
				overflow_q <= overflow_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer && frame.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && frame.last) begin
			status_q    <= status_new;
			frame_seq_q <= seq_new;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = status_q;
	assign result.frame_seq = frame_seq_q;

endmodule

/* sv/pfc_checker.sv */
// pfc_checker: port-level assertions for prbs_frame_checker, attached by bind
// depends on prbs_frame_checker and its channel interfaces

module pfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_seq
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_seq))
		else $error("result changed while stalled");

	// every last word transfer gives a result in the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("no result after last word");

	// a result comes only from a last word or is one still held
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid && in_ready && in_last) || $past(out_valid && !out_ready))
		else $error("result without a last word");

	// input never stalls while the result register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free result register");

endmodule

bind prbs_frame_checker pfc_checker u_pfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (frame.valid),
	.in_ready   (frame.ready),
	.in_last    (frame.last),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_seq    (result.frame_seq)
);

/* tb/sv/tb_prbs_frame_checker.sv */
// tb_prbs_frame_checker: self-checking bench for the prbs frame checker, directed and random frames
// depends on pfc_pkg, the channel interfaces in pfc_if.sv and prbs_frame_checker
// a local model of the frame state predicts one status per frame, compared in order of arrival

module tb_prbs_frame_checker;
	timeunit 1ns;
	timeprecision 1ps;
	import pfc_pkg::*;

	localparam int MIN_FRAME = DEF_MIN_WORDS;
	localparam int MAX_FRAME = DEF_MAX_WORDS;
	localparam int RANDOM_WORDS = 650;
	localparam int CYCLE_LIMIT = 100000;
	localparam int NO_ERR = -1;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] seq;
	} frame_result_t;

	logic clk;
	logic arst_n;

	pfc_in_if  frame_if ();
	pfc_out_if result_if ();

	prbs_frame_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.result (result_if)
	);

	// expected frame status, oldest first
	frame_result_t pending_status[$];
	int unsigned mismatch_count = 0;
	int unsigned words_sent = 0;
	int unsigned cycle_count = 0;

	// local frame state
	int unsigned       word_cnt = 0;
	logic [WORD_W-1:0] exp_lfsr = '0;
	logic [WORD_W-1:0] hdr_seq = '0;
	logic [WORD_W-1:0] len_word = '0;
	logic              data_bad = 1'b0;
	logic              cnt_sat = 1'b0;

	// sender bursts
	logic gap_enable = 1'b1;
	int   burst_left = 0;

	// receiver stall pattern
	logic [15:0] stall_pat = 16'hffff;
	logic [3:0]  stall_tick = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [WORD_W-1:0] prbs_step(input logic [WORD_W-1:0] cur);
		return {cur[WORD_W-2:0], cur[1] ^ cur[2] ^ cur[6] ^ cur[31]};
	endfunction

	task automatic predict_frame_status(input logic [WORD_W-1:0] w, input logic l);
		frame_result_t res;
		logic [31:0]   len_bytes;
		logic [31:0]   frame_bytes;
		if (word_cnt == 0) begin
			hdr_seq = w;
			exp_lfsr = w;
		end else if (word_cnt == 1) begin
			len_word = w;
		end else begin
			exp_lfsr = prbs_step(exp_lfsr);
			if (w != exp_lfsr)
				data_bad = 1'b1;
		end
		if (word_cnt < MAX_FRAME)
			word_cnt++;
		else
			cnt_sat = 1'b1;
		if (l) begin
			len_bytes = len_word * 32'd4 + 32'd4;
			frame_bytes = 32'(word_cnt) * 32'd4;
			if (word_cnt < MIN_FRAME)
				res.status = ST_SHORT;
			else if (cnt_sat || len_bytes != frame_bytes)
				res.status = ST_LEN;
			else if (data_bad)
				res.status = ST_DATA;
			else
				res.status = ST_OK;
			res.seq = hdr_seq;
			pending_status.push_back(res);
			word_cnt = 0;
			exp_lfsr = '0;
			hdr_seq = '0;
			len_word = '0;
			data_bad = 1'b0;
			cnt_sat = 1'b0;
		end
	endtask

	task automatic push_word(input logic [WORD_W-1:0] w, input logic l);
		int gap;
		if (gap_enable && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				frame_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		frame_if.valid <= 1'b1;
		frame_if.word <= w;
		frame_if.last <= l;
		do @(posedge clk); while (!frame_if.ready);
		predict_frame_status(w, l);
		words_sent++;
		burst_left--;
	endtask

	task automatic send_frame(input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] lenf,
			input int nwords, input int bad_idx, input logic [WORD_W-1:0] bad_mask);
		logic [WORD_W-1:0] gen;
		logic [WORD_W-1:0] w;
		gen = seq;
		for (int i = 0; i < nwords; i++) begin
			if (i == 0) begin
				w = seq;
			end else if (i == 1) begin
				w = lenf;
			end else begin
				gen = prbs_step(gen);
				w = (i == bad_idx) ? gen ^ bad_mask : gen;
			end
			push_word(w, i == nwords - 1);
		end
	endtask

	task automatic wait_results_drained();
		frame_if.valid <= 1'b0;
		do @(posedge clk); while (pending_status.size() != 0);
	endtask

	task automatic test_directed_frames();
		send_frame(32'h0000_0000, 32'd2, 3, NO_ERR, '0);
		send_frame(32'hffff_ffff, 32'd3, 4, NO_ERR, '0);
		send_frame(32'ha5a5_a5a5, '0, 1, NO_ERR, '0);
		send_frame(32'h5a5a_5a5a, 32'd1, 2, NO_ERR, '0);
		send_frame(32'h1234_5678, 32'd5, 3, NO_ERR, '0);
		send_frame(32'h8000_0001, 32'd3, 4, 3, 32'h8000_0000);
		// length error outranks payload error
		send_frame(32'h0f0f_0f0f, 32'd7, 3, 2, 32'h0000_0001);
		// length field aliases to the right byte count after wrap
		send_frame(32'hdead_beef, 32'h4000_0002, 3, NO_ERR, '0);
		send_frame(32'h7fff_ffff, 32'hffff_ffff, 3, NO_ERR, '0);
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int          pick;
		int          n;
		int          bad_idx;
		logic [31:0] lenf;
		logic [31:0] mask;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 120) : $urandom_range(3, 26);
			if (pick < 70) begin
				lenf = n - 1;
				if ($urandom_range(0, 7) == 0)
					lenf[31:30] = 2'($urandom);
				bad_idx = NO_ERR;
				mask = '0;
				if ($urandom_range(0, 4) == 0) begin
					bad_idx = $urandom_range(2, n - 1);
					mask = ($urandom_range(0, 1) == 0) ? 32'h1 << $urandom_range(0, 31)
						: $urandom | 32'h1;
				end
				send_frame($urandom, lenf, n, bad_idx, mask);
			end else if (pick < 80) begin
				lenf = ($urandom_range(0, 1) == 0) ? 32'(n - 1 + $urandom_range(1, 4)) : $urandom;
				if (lenf == n - 1)
					lenf++;
				send_frame($urandom, lenf, n, NO_ERR, '0);
			end else if (pick < 90) begin
				send_frame($urandom, $urandom, $urandom_range(1, 2), NO_ERR, '0);
			end else begin
				n = $urandom_range(1, 16);
				for (int i = 0; i < n; i++)
					push_word($urandom, i == n - 1);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_tick == 0)
			stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom) | 16'h1;
		else
			stall_pat <= {stall_pat[14:0], stall_pat[15]};
		stall_tick <= stall_tick + 1'b1;
		result_if.ready <= stall_pat[0];
	end

	always @(posedge clk) begin
		frame_result_t exp_res;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_status.size() == 0) begin
				$error("unexpected result transfer: status %0d, frame_seq %h",
					result_if.status, result_if.frame_seq);
				mismatch_count++;
			end else begin
				exp_res = pending_status.pop_front();
				if (result_if.status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, result_if.status);
					mismatch_count++;
				end
				if (result_if.frame_seq !== exp_res.seq) begin
					$error("frame_seq: expected %h, got %h", exp_res.seq, result_if.frame_seq);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_prbs_frame_checker failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		frame_if.word = '0;
		frame_if.last = 1'b0;
		result_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		wait_results_drained();
		test_random_frames();
		wait_results_drained();
		test_random_frames();
		wait_results_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("tb_prbs_frame_checker passed");
		else
			$display("tb_prbs_frame_checker failed");
		$finish;
	end

endmodule

/* prbs_frame_checker.f */
sv/pfc_pkg.sv
sv/pfc_if.sv
sv/prbs_frame_checker.sv
sv/pfc_checker.sv
tb/sv/tb_prbs_frame_checker.sv
